// File: sv/lcer_pkg.sv
package lcer_pkg;

  localparam int CodeWidth  = 5;
  localparam int ExpoWidth  = 16;
  localparam int CountWidth = 8;
  localparam int CfgWidth   = 16;
  localparam int IndexWidth = 3;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_RAISE = 2'd1,
    MODE_LOWER = 2'd2
  } mode_t;

  typedef enum logic [IndexWidth-1:0] {
    REG_SETTLE_COUNT = 3'd0,
    REG_START_RAISE  = 3'd1,
    REG_START_LOWER  = 3'd2,
    REG_KEEP_RAISE   = 3'd3,
    REG_KEEP_LOWER   = 3'd4,
    REG_CURRENT_MAX  = 3'd5,
    REG_CURRENT_MIN  = 3'd6,
    REG_CURRENT_STEP = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [CountWidth-1:0] settle_count;
    logic [ExpoWidth-1:0]  start_raise_bound;
    logic [ExpoWidth-1:0]  start_lower_bound;
    logic [ExpoWidth-1:0]  keep_raise_level;
    logic [ExpoWidth-1:0]  keep_lower_level;
    logic [CodeWidth-1:0]  current_max;
    logic [CodeWidth-1:0]  current_min;
    logic [CodeWidth-1:0]  current_step;
  } cfg_t;

  typedef struct packed {
    logic [CountWidth-1:0] frame_counter;
    mode_t                 mode;
    logic [CodeWidth-1:0]  drive_code;
  } reg_state_t;

  localparam cfg_t CfgReset = '{
    settle_count:      8'd4,
    start_raise_bound: 16'd40000,
    start_lower_bound: 16'd10000,
    keep_raise_level:  16'd30000,
    keep_lower_level:  16'd20000,
    current_max:       5'd31,
    current_min:       5'd1,
    current_step:      5'd2
  };

endpackage

// File: sv/lcer_adjust.sv
module lcer_adjust
  import lcer_pkg::*;
(
  input  cfg_t                 cfg,
  input  reg_state_t           cur,
  input  logic                 touched,
  input  logic [ExpoWidth-1:0] exposure,
  output reg_state_t           nxt,
  output logic                 changed
);

  logic [CodeWidth:0]   sum;
  logic [CodeWidth:0]   low_edge;
  logic [CodeWidth:0]   max_wide;
  logic [CodeWidth-1:0] lowered;
  logic                 near_floor;

  assign sum        = {1'b0, cur.drive_code} + {1'b0, cfg.current_step};
  assign low_edge   = {1'b0, cfg.current_min} + {1'b0, cfg.current_step};
  assign max_wide   = {1'b0, cfg.current_max};
  assign near_floor = {1'b0, cur.drive_code} <= low_edge;
  assign lowered    = near_floor ? cfg.current_min : (cur.drive_code - cfg.current_step);

  always_comb begin
    nxt     = cur;
    changed = 1'b0;
    if (touched) begin
      if (cur.frame_counter <= cfg.settle_count) begin
        nxt.frame_counter = cur.frame_counter + 1'b1;
      end else begin
        nxt.frame_counter = '0;
        case (cur.mode)
          MODE_RAISE: begin
            nxt.mode = MODE_IDLE;
            if (exposure > cfg.keep_raise_level) begin
              changed = 1'b1;
              if (sum >= max_wide) begin
                nxt.drive_code = cfg.current_max;
              end else begin
                nxt.mode       = MODE_RAISE;
                nxt.drive_code = sum[CodeWidth-1:0];
              end
            end
          end
          MODE_LOWER: begin
            nxt.mode = MODE_IDLE;
            if (exposure < cfg.keep_lower_level) begin
              changed        = 1'b1;
              nxt.drive_code = lowered;
              if (!near_floor) begin
                nxt.mode = MODE_LOWER;
              end
            end
          end
          default: begin
            // unused mode code behaves as idle
            nxt.mode = MODE_IDLE;
            if (exposure >= cfg.start_raise_bound && cur.drive_code < cfg.current_max) begin
              nxt.mode       = MODE_RAISE;
              nxt.drive_code = (sum > max_wide) ? cfg.current_max : sum[CodeWidth-1:0];
              changed        = 1'b1;
            end else if (exposure <= cfg.start_lower_bound &&
                         cur.drive_code > cfg.current_min) begin
              nxt.mode       = MODE_LOWER;
              nxt.drive_code = lowered;
              changed        = 1'b1;
            end
          end
        endcase
      end
    end
  end

endmodule

// File: sv/led_current_exposure_regulator.sv
// LED current exposure regulator.
// Input channel (in_valid/in_ready) carries one item per sensor frame: the
// touch flag and the exposure in lines. Output channel (out_valid/out_ready)
// returns one item per input item: the LED current code, a changed flag and
// the adjust mode (idle, raising, lowering).
// Configuration: pulse cfg_we with cfg_index and cfg_data; write only while
// no item is in flight. Registers narrower than cfg_data take its low bits.
// An accepted item sits in the input register, and its result is registered
// in the output register when the receiver is not stalling the output side.
// Throughput: one item per cycle while results are taken; the regulator state
// (frame counter, mode, drive code) is updated in the same cycle that forms the result.
// A stalled receiver holds the result register; the input register takes at
// most one more item, then in_ready drops until the result is taken.
// Reset: both pipeline registers empty, registers back to their defaults,
// frame counter and drive code zero, mode idle.
module led_current_exposure_regulator
  import lcer_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  touched,
  input  logic [ExpoWidth-1:0]  exposure,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CodeWidth-1:0]  led_current,
  output logic                  current_changed,
  output logic [1:0]            adjust_mode,
  input  logic                  cfg_we,
  input  logic [IndexWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0]   cfg_data
);

  cfg_t                 cfg;
  reg_state_t           state;
  reg_state_t           state_next;
  logic                 changed_next;
  logic                 s1_valid;
  logic                 s1_touched;
  logic [ExpoWidth-1:0] s1_exposure;
  logic                 advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance || !s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CfgReset;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_SETTLE_COUNT: cfg.settle_count      <= cfg_data[CountWidth-1:0];
        REG_START_RAISE:  cfg.start_raise_bound <= cfg_data[ExpoWidth-1:0];
        REG_START_LOWER:  cfg.start_lower_bound <= cfg_data[ExpoWidth-1:0];
        REG_KEEP_RAISE:   cfg.keep_raise_level  <= cfg_data[ExpoWidth-1:0];
        REG_KEEP_LOWER:   cfg.keep_lower_level  <= cfg_data[ExpoWidth-1:0];
        REG_CURRENT_MAX:  cfg.current_max       <= cfg_data[CodeWidth-1:0];
        REG_CURRENT_MIN:  cfg.current_min       <= cfg_data[CodeWidth-1:0];
        REG_CURRENT_STEP: cfg.current_step      <= cfg_data[CodeWidth-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_touched  <= touched;
      s1_exposure <= exposure;
    end
  end

  lcer_adjust u_adjust (
    .cfg      (cfg),
    .cur      (state),
    .touched  (s1_touched),
    .exposure (s1_exposure),
    .nxt      (state_next),
    .changed  (changed_next)
  );

  // commit state and result together when the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '{frame_counter: '0, mode: MODE_IDLE, drive_code: '0};
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        state <= state_next;
      end
    end
    if (advance && s1_valid) begin
      led_current     <= state_next.drive_code;
      current_changed <= changed_next;
      adjust_mode     <= state_next.mode;
    end
  end

endmodule

// File: sv/lcer_checker.sv
module lcer_props
  import lcer_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CodeWidth-1:0] led_current,
  input logic                 current_changed,
  input logic [1:0]           adjust_mode
);

  // a stalled result must hold
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(led_current) &&
      $stable(current_changed) && $stable(adjust_mode))
    else $error("stalled result changed");

  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // an empty result slot never blocks the input side
  assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> adjust_mode != 2'd3)
    else $error("unused adjust mode on output");

endmodule

bind led_current_exposure_regulator lcer_props u_lcer_props (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .led_current     (led_current),
  .current_changed (current_changed),
  .adjust_mode     (adjust_mode)
);
